/* hw/rtl/first_fit_region_allocator_top_macros.svh */
// Assertion macros for the region allocator.
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define FFRA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FFRA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FFRA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define FFRA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* hw/rtl/ffra_pkg.sv */
// Shared types and constants for the region allocator.
package ffra_pkg;
    localparam int DEF_MAX_CHUNKS  = 64;
    localparam int DEF_OFFSET_BITS = 32;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic CFG_ALIGN = 1'b0;
    localparam logic CFG_POOL  = 1'b1;

    // Per-cycle command that the controller broadcasts to every cell
    typedef enum logic [5:0] {
        OP_NONE   = 6'b000001,
        OP_RELOAD = 6'b000010,
        OP_SHRINK = 6'b000100,
        OP_DELETE = 6'b001000,
        OP_INSERT = 6'b010000,
        OP_SETLEN = 6'b100000
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] need;
    } cell_cmd_t;
endpackage

/* hw/rtl/ffra_cell.sv */
// One table slot: holds a free chunk and shifts with its neighbors.
module ffra_cell import ffra_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cell_cmd_t   cmd,
    input  logic        is_first,
    input  logic        sel_here,    // this slot is the target index
    input  logic        past_sel,    // this slot lies above the target index
    input  logic        left_valid,
    input  logic [31:0] left_start,
    input  logic [31:0] left_length,
    input  logic        right_valid,
    input  logic [31:0] right_start,
    input  logic [31:0] right_length,
    output logic        valid,
    output logic [31:0] start,
    output logic [31:0] length
);
    logic        valid_reg, valid_next;
    logic [31:0] start_reg, start_next, length_reg, length_next;

    // Apply the broadcast command to this slot
    always_comb begin
        valid_next  = valid_reg;
        start_next  = start_reg;
        length_next = length_reg;
        case (cmd.op)
            OP_RELOAD: begin
                valid_next  = is_first && (cmd.length != 32'd0);
                start_next  = 32'd0;
                length_next = cmd.length;
            end
            OP_SHRINK: begin
                if (sel_here) begin
                    start_next  = start_reg + cmd.need;
                    length_next = length_reg - cmd.need;
                end
            end
            OP_DELETE: begin
                if (sel_here || past_sel) begin
                    valid_next  = right_valid;
                    start_next  = right_start;
                    length_next = right_length;
                end
            end
            OP_INSERT: begin
                if (sel_here) begin
                    valid_next  = 1'b1;
                    start_next  = cmd.start;
                    length_next = cmd.length;
                end else if (past_sel) begin
                    valid_next  = left_valid;
                    start_next  = left_start;
                    length_next = left_length;
                end
            end
            OP_SETLEN: begin
                if (sel_here) begin
                    start_next  = cmd.start;
                    length_next = cmd.length;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= is_first;
            start_reg  <= 32'd0;
            length_reg <= 32'd65536;
        end else begin
            valid_reg  <= valid_next;
            start_reg  <= start_next;
            length_reg <= length_next;
        end
    end

    assign valid  = valid_reg;
    assign start  = start_reg;
    assign length = length_reg;
endmodule

/* hw/rtl/ffra_ctrl.sv */
// Request sequencer: searches the cell row and issues table edits.
module ffra_ctrl import ffra_pkg::*; #(
    parameter int MAX_CHUNKS  = DEF_MAX_CHUNKS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_idx,
    input  logic [31:0]            cfg_data,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   req_type,
    input  logic [31:0]            req_offset,
    input  logic [31:0]            req_size,
    input  logic [MAX_CHUNKS-1:0]  cell_valid,
    input  logic [MAX_CHUNKS-1:0][31:0] cell_start,
    input  logic [MAX_CHUNKS-1:0][31:0] cell_length,
    output cell_cmd_t              cmd,
    output logic [MAX_CHUNKS-1:0]  sel_here,
    output logic [MAX_CHUNKS-1:0]  past_sel,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [97:0]            res_data
);
    localparam logic [32:0] LIM = (OFFSET_BITS >= 32) ? 33'h0_FFFF_FFFF
                                 : ((33'd1 << OFFSET_BITS) - 33'd1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_EVAL = 4'b0010, S_EDIT = 4'b0100, S_OUT = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic        type_reg;
    logic [31:0] off_reg, size_reg, need_reg;
    logic [4:0]  align_reg;
    logic [31:0] id_reg;
    logic [MAX_CHUNKS-1:0] hit_reg, lt_reg;
    cell_cmd_t   cmd_reg;
    logic [MAX_CHUNKS-1:0] sel_reg;
    logic [1:0]  st_reg;
    logic [31:0] go_reg, gs_reg, gid_reg;
    logic        out_v_reg;
    logic        dbl_pend_reg, dbl_reg;

    logic [32:0] need_w, amask;
    assign amask  = (33'd1 << align_reg) - 33'd1;
    assign need_w = ({1'b0, req_size & LIM[31:0]} + amask) & ~amask;

    // One-hot first hit, right neighbor at p and left neighbor at p-1
    logic [MAX_CHUNKS-1:0] first_hit, pmask, lmask;
    logic [MAX_CHUNKS-1:0] lt_w, hit_w;
    always_comb begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            hit_w[i] = cell_valid[i] && (cell_length[i] >= need_reg);
            lt_w[i]  = cell_valid[i] && (cell_start[i] < off_reg);
        end
        first_hit = hit_reg & (~hit_reg + {{(MAX_CHUNKS-1){1'b0}}, 1'b1});
        pmask = ~lt_reg & (lt_reg + {{(MAX_CHUNKS-1){1'b0}}, 1'b1});
        lmask = lt_reg & ~(lt_reg >> 1);
    end

    // Gather neighbors by one-hot select
    logic [31:0] hs, hl, ls, ll, rs, rl;
    logic        lv, rv;
    always_comb begin
        hs = '0; hl = '0; ls = '0; ll = '0; rs = '0; rl = '0; lv = 1'b0; rv = 1'b0;
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            if (first_hit[i]) begin hs |= cell_start[i]; hl |= cell_length[i]; end
            if (lmask[i]) begin ls |= cell_start[i]; ll |= cell_length[i];
                lv |= cell_valid[i]; end
            if (pmask[i]) begin rs |= cell_start[i]; rl |= cell_length[i];
                rv |= cell_valid[i]; end
        end
    end

    logic [32:0] end_w, nl_w, sum_r;
    logic        left_ok, right_ok;
    always_comb begin
        end_w   = {1'b0, off_reg} + {1'b0, size_reg};
        left_ok = lv && (({1'b0, ls} + {1'b0, ll}) == {1'b0, off_reg})
                  && (({1'b0, ll} + {1'b0, size_reg}) <= LIM);
        nl_w    = left_ok ? {1'b0, ll} + {1'b0, size_reg} : {1'b0, size_reg};
        sum_r   = nl_w + {1'b0, rl};
        right_ok = rv && ({1'b0, rs} == end_w) && (sum_r <= LIM);
    end

    // Decide the edit, the status and whether a block is granted
    op_t                   edit_op;
    logic [MAX_CHUNKS-1:0] edit_sel;
    logic [31:0]           edit_start, edit_len;
    logic [1:0]            edit_st;
    logic                  grant_w;
    always_comb begin
        edit_op    = OP_NONE;
        edit_sel   = sel_reg;
        edit_start = off_reg;
        edit_len   = size_reg;
        edit_st    = ST_OK;
        grant_w    = 1'b0;
        if (!type_reg) begin
            if (st_reg == ST_OK && |hit_reg) begin
                grant_w  = 1'b1;
                edit_sel = first_hit;
                edit_op  = (hl == need_reg) ? OP_DELETE : OP_SHRINK;
            end else begin
                edit_st = ST_NOFIT;
            end
        end else if (size_reg != 32'd0) begin
            if (left_ok) begin
                edit_sel   = lmask;
                edit_op    = OP_SETLEN;
                edit_start = ls;
                edit_len   = right_ok ? sum_r[31:0] : nl_w[31:0];
            end else if (right_ok) begin
                edit_sel   = pmask;
                edit_op    = OP_SETLEN;
                edit_start = off_reg;
                edit_len   = sum_r[31:0];
            end else if (cell_valid[MAX_CHUNKS-1]) begin
                edit_st = ST_FULL;
            end else begin
                edit_sel = pmask;
                edit_op  = OP_INSERT;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req_valid) state_next = S_EVAL;
            S_EVAL: state_next = S_EDIT;
            S_EDIT: state_next = S_OUT;
            S_OUT:  if (res_ready || !out_v_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            align_reg  <= 5'd0;
            id_reg     <= 32'd0;
            out_v_reg  <= 1'b0;
            cmd_reg.op <= OP_NONE;
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_idx == CFG_ALIGN) align_reg <= cfg_data[4:0];
            // Issue at most one command per cycle
            if (cfg_we && cfg_idx == CFG_POOL) begin
                cmd_reg.op     <= OP_RELOAD;
                cmd_reg.length <= cfg_data & LIM[31:0];
            end else if (state_reg == S_EDIT) begin
                cmd_reg.op     <= edit_op;
                cmd_reg.start  <= edit_start;
                cmd_reg.length <= edit_len;
                cmd_reg.need   <= need_reg;
                sel_reg        <= edit_sel;
            end else begin
                cmd_reg.op <= OP_NONE;
            end
            // Raise the result after the edit, drop it when taken
            if (state_reg == S_EDIT) out_v_reg <= 1'b1;
            else if (res_ready) out_v_reg <= 1'b0;
            // Capture the request
            if (state_reg == S_IDLE && req_valid) begin
                type_reg <= req_type;
                off_reg  <= req_offset & LIM[31:0];
                size_reg <= req_size & LIM[31:0];
                need_reg <= need_w[31:0];
                st_reg   <= ((need_w > LIM) || (req_size & LIM[31:0]) == 32'd0)
                            ? ST_NOFIT : ST_OK;
            end else if (state_reg == S_EDIT) begin
                st_reg <= edit_st;
            end
            // Register the per-cell compares
            if (state_reg == S_EVAL) begin
                hit_reg <= hit_w;
                lt_reg  <= lt_w;
            end
            // Load the grant fields
            if (state_reg == S_EDIT) begin
                go_reg  <= grant_w ? hs : 32'd0;
                gs_reg  <= grant_w ? need_reg : 32'd0;
                gid_reg <= grant_w ? id_reg : 32'd0;
                if (grant_w) id_reg <= id_reg + 32'd1;
            end
        end
    end

    // Double merge: remove the right chunk in the cycle after the setlen lands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbl_pend_reg <= 1'b0;
            dbl_reg      <= 1'b0;
        end else begin
            dbl_pend_reg <= (state_reg == S_EDIT) && type_reg && size_reg != 32'd0
                            && left_ok && right_ok;
            dbl_reg      <= dbl_pend_reg;
        end
    end

    always_comb begin
        cmd = cmd_reg;
        sel_here = sel_reg;
        if (dbl_reg) begin
            cmd.op = OP_DELETE;
            sel_here = sel_reg << 1;
        end
        past_sel = '0;
        for (int i = 1; i < MAX_CHUNKS; i++)
            past_sel[i] = past_sel[i-1] | sel_here[i-1];
    end

    assign res_valid = out_v_reg;
    assign res_data  = {gid_reg, gs_reg, go_reg, st_reg};
endmodule

/* hw/rtl/first_fit_region_allocator_top.sv */
// Top level of the first-fit region allocator.
// Usage: requests enter on s_axis (tdata = req_type, req_offset, req_size),
// results leave on m_axis (tdata = status, grant_offset, grant_size, block_id).
// Each request yields exactly one result item.
// The free list lives in a row of MAX_CHUNKS cells that shift entries to
// their neighbors for inserts and deletes; the sequencer searches every
// cell in parallel and broadcasts one edit command per cycle.
// Sequencing: the result is registered after the request passes the eval and
// edit states; one request is in work at a time, so the next request waits
// until the result is taken on m_axis_tready.
// Configuration: cfg_we/cfg_idx/cfg_wdata; index 0 align_log2, index 1
// pool_size (reloads the table with one chunk, none for size 0). Write only while idle.
// Reset: aresetn low clears the table to one chunk [0, 65536), alignment 1
// and block ids to 0. When the receiver stalls the result holds and no new
// request is accepted until it is taken.
module first_fit_region_allocator_top import ffra_pkg::*; #(
    parameter int MAX_CHUNKS  = DEF_MAX_CHUNKS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_idx,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // req_type, req_offset, req_size, pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // status, grant_offset, grant_size, block_id, pad
);
    `include "first_fit_region_allocator_top_macros.svh"

    logic [MAX_CHUNKS-1:0]       cv, sh, ps;
    logic [MAX_CHUNKS-1:0][31:0] cs, cl;
    cell_cmd_t cmd;
    logic [97:0] rd;

    ffra_ctrl #(.MAX_CHUNKS(MAX_CHUNKS), .OFFSET_BITS(OFFSET_BITS)) u_ctrl (
        .aclk, .aresetn, .cfg_we, .cfg_idx, .cfg_data(cfg_wdata),
        .req_valid(s_axis_tvalid), .req_ready(s_axis_tready),
        .req_type(s_axis_tdata[0]), .req_offset(s_axis_tdata[32:1]),
        .req_size(s_axis_tdata[64:33]),
        .cell_valid(cv), .cell_start(cs), .cell_length(cl),
        .cmd, .sel_here(sh), .past_sel(ps),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(rd)
    );

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
        ffra_cell u_cell (
            .aclk, .aresetn, .cmd, .is_first(i == 0),
            .sel_here(sh[i]), .past_sel(ps[i]),
            .left_valid(i > 0 ? cv[(i > 0) ? i-1 : 0] : 1'b0),
            .left_start(cs[(i > 0) ? i-1 : 0]), .left_length(cl[(i > 0) ? i-1 : 0]),
            .right_valid(i < MAX_CHUNKS-1 ? cv[(i < MAX_CHUNKS-1) ? i+1 : i] : 1'b0),
            .right_start(cs[(i < MAX_CHUNKS-1) ? i+1 : i]),
            .right_length(cl[(i < MAX_CHUNKS-1) ? i+1 : i]),
            .valid(cv[i]), .start(cs[i]), .length(cl[i])
        );
    end

    assign m_axis_tdata = {6'd0, rd};

    `FFRA_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `FFRA_ASSERT_IMPL(a_status_range, aclk, aresetn, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    `FFRA_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

/* tb/sv/ffra_checker.sv */
// Checker for the region allocator: predicts each result and compares it.
module ffra_checker import ffra_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_idx,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    output int           fail_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCHUNK = DEF_MAX_CHUNKS;
    localparam logic [32:0] LEN_MAX = 33'hFFFF_FFFF;

    // Fields from the highest bits down, matching the result tdata packing
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] size;
        logic [31:0] offset;
        logic [1:0]  status;
    } grant_t;

    logic [31:0] free_start [NCHUNK];
    logic [31:0] free_len [NCHUNK];
    int          free_cnt;
    logic [31:0] id_next;
    logic [4:0]  align_sh;
    logic [31:0] pool_bytes;
    grant_t      grant_q[$];

    // Refill the free table with the whole pool
    task automatic reload_pool();
        free_cnt = 0;
        if (pool_bytes != 0) begin
            free_start[0] = 0;
            free_len[0] = pool_bytes;
            free_cnt = 1;
        end
    endtask

    task automatic drop_chunk(int i);
        for (int k = i; k + 1 < free_cnt; k++) begin
            free_start[k] = free_start[k + 1];
            free_len[k] = free_len[k + 1];
        end
        free_cnt--;
    endtask

    // Work out the grant for one request and update the free table
    task automatic predict_grant(logic kind, logic [31:0] off, logic [31:0] sz);
        grant_t g;
        logic [32:0] a, need, fend, nlen;
        int p;
        bit lft, rgt, hit;
        g = '0;
        if (kind == 1'b0) begin
            a = 33'd1 << align_sh;
            need = ({1'b0, sz} + a - 1) & ~(a - 1);
            if (sz == 0 || need > LEN_MAX) begin
                g.status = ST_NOFIT;
            end else begin
                g.status = ST_NOFIT;
                hit = 0;
                for (int i = 0; i < free_cnt && !hit; i++) begin
                    if ({1'b0, free_len[i]} >= need) begin
                        hit = 1;
                        g.status = ST_OK;
                        g.offset = free_start[i];
                        g.size = need[31:0];
                        g.id = id_next;
                        id_next++;
                        if ({1'b0, free_len[i]} == need) begin
                            drop_chunk(i);
                        end else begin
                            free_start[i] += need[31:0];
                            free_len[i] -= need[31:0];
                        end
                    end
                end
            end
        end else if (sz != 0) begin
            g.status = ST_OK;
            fend = {1'b0, off} + sz;
            nlen = {1'b0, sz};
            p = 0;
            while (p < free_cnt && free_start[p] < off) p++;
            lft = p > 0 && ({1'b0, free_start[p-1]} + free_len[p-1]) == {1'b0, off}
                  && ({1'b0, free_len[p-1]} + sz) <= LEN_MAX;
            if (lft) nlen += free_len[p-1];
            rgt = p < free_cnt && {1'b0, free_start[p]} == fend
                  && (nlen + free_len[p]) <= LEN_MAX;
            if (lft && rgt) begin
                free_len[p-1] = nlen[31:0] + free_len[p];
                drop_chunk(p);
            end else if (lft) begin
                free_len[p-1] = nlen[31:0];
            end else if (rgt) begin
                free_start[p] = off;
                free_len[p] = sz + free_len[p];
            end else if (free_cnt >= NCHUNK) begin
                g.status = ST_FULL;
            end else begin
                for (int k = free_cnt; k > p; k--) begin
                    free_start[k] = free_start[k-1];
                    free_len[k] = free_len[k-1];
                end
                free_start[p] = off;
                free_len[p] = sz;
                free_cnt++;
            end
        end
        grant_q.push_back(g);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Track config, predict on accepted requests, compare accepted results
    always @(posedge aclk) begin
        grant_t got, want;
        if (!aresetn) begin
            align_sh = 0;
            pool_bytes = 32'd65536;
            id_next = 0;
            reload_pool();
            grant_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_ALIGN) begin
                    align_sh = cfg_wdata[4:0];
                end else begin
                    pool_bytes = cfg_wdata;
                    reload_pool();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[97:0];
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected result", got.offset, 0);
                end else begin
                    want = grant_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.offset != want.offset)
                        report_mismatch("grant_offset", got.offset, want.offset);
                    if (got.size != want.size)
                        report_mismatch("grant_size", got.size, want.size);
                    if (got.id != want.id)
                        report_mismatch("block_id", got.id, want.id);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_grant(s_axis_tdata[0], s_axis_tdata[32:1], s_axis_tdata[64:33]);
        end
        pending_count = grant_q.size();
    end
endmodule

/* tb/sv/tb_first_fit_region_allocator_top.sv */
// Testbench top for the region allocator: stimulus, idling and verdict.
module tb_first_fit_region_allocator_top import ffra_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic         cfg_idx;
    logic [31:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;   // req_type, req_offset, req_size, pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // status, grant_offset, grant_size, block_id, pad
    int           fail_count;
    int           pending_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    longint       cycle_count;
    logic [31:0]  held_off [$];
    logic [31:0]  held_size [$];

    first_fit_region_allocator_top u_top (.*);

    ffra_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Stop a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // Send one request, with a random gap before it
    task automatic send_req(logic kind, logic [31:0] off, logic [31:0] sz);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {7'd0, sz, off, kind};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        s_axis_tvalid <= 0;
    endtask

    task automatic wait_drain();
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Allocate, remembering granted regions to free later
    task automatic alloc_rand(logic [31:0] sz);
        send_req(1'b0, 0, sz);
        wait_drain_one();
    endtask

    task automatic wait_drain_one();
        @(posedge aclk);
        while (!(m_axis_tvalid && m_axis_tready)) @(posedge aclk);
        if (m_axis_tdata[1:0] == ST_OK) begin
            held_off.push_back(m_axis_tdata[33:2]);
            held_size.push_back(m_axis_tdata[65:34]);
        end
    endtask

    task automatic random_phase(int n);
        int j;
        logic [31:0] sz;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    sz = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 3000);
                    alloc_rand(sz);
                end
                4, 5, 6, 7: begin
                    if (held_off.size() > 0) begin
                        j = $urandom_range(held_off.size() - 1);
                        send_req(1'b1, held_off[j], held_size[j]);
                        held_off.delete(j);
                        held_size.delete(j);
                    end else begin
                        send_req(1'b0, 0, $urandom_range(1, 500));
                    end
                end
                8: send_req(1'b1, $urandom, $urandom);
                default: send_req($urandom_range(1), $urandom, $urandom_range(0, 2));
            endcase
        end
    endtask

    initial begin
        aresetn = 0;
        cfg_we = 0;
        cfg_idx = 0;
        cfg_wdata = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: field extremes, zero sizes, big alignment, zero pool
        send_req(1'b0, 32'hFFFF_FFFF, 0);
        send_req(1'b0, 0, 1);
        send_req(1'b0, 0, 32'hFFFF_FFFF);
        send_req(1'b1, 0, 0);
        send_req(1'b1, 0, 1);
        send_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(1'b0, 0, 65535);
        send_req(1'b0, 0, 2);
        wait_drain();
        write_reg(CFG_ALIGN, 5'd31);
        write_reg(CFG_POOL, 32'hFFFF_FFFF);
        send_req(1'b0, 0, 1);
        send_req(1'b0, 0, 32'h8000_0001);
        wait_drain();
        write_reg(CFG_ALIGN, 5'd16);
        send_req(1'b0, 0, 1);
        send_req(1'b0, 0, 32'hFFFF_0001);
        wait_drain();
        write_reg(CFG_POOL, 0);
        send_req(1'b0, 0, 1);
        send_req(1'b1, 100, 50);
        send_req(1'b1, 150, 50);
        send_req(1'b1, 50, 50);
        send_req(1'b0, 0, 150);
        wait_drain();

        // Fill the table until it overflows, small pool, no alignment
        write_reg(CFG_ALIGN, 0);
        write_reg(CFG_POOL, 1);
        for (int i = 0; i < 66; i++) send_req(1'b1, 10 + 4 * i, 2);
        wait_drain();

        // Random phases over several settings and idling mixes
        held_off.delete();
        held_size.delete();
        send_idle_pct = 29;
        recv_idle_pct = 47;
        write_reg(CFG_ALIGN, 3);
        write_reg(CFG_POOL, 32'd20000);
        random_phase(155);
        wait_drain();
        held_off.delete();
        held_size.delete();
        send_idle_pct = 47;
        recv_idle_pct = 29;
        write_reg(CFG_ALIGN, 0);
        write_reg(CFG_POOL, 32'd65536);
        random_phase(155);
        wait_drain();
        held_off.delete();
        held_size.delete();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_ALIGN, 6);
        write_reg(CFG_POOL, 32'd50000);
        random_phase(155);
        wait_drain();

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_cell.sv
hw/rtl/ffra_ctrl.sv
hw/rtl/first_fit_region_allocator_top.sv
tb/sv/ffra_checker.sv
tb/sv/tb_first_fit_region_allocator_top.sv
